// File: hdl/bbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbm_pkg
// Shared types and constants of the bounded big-number multiplier.
// ----------------------------------------------------------------------------
package bbm_pkg;

    localparam int MAX_WIDTH_BYTES_DEF  = 256;
    localparam int MAX_FACTOR_BYTES_DEF = 256;
    localparam logic [8:0] WIDTH_RESET  = 9'd256;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_FACTOR = 2'd1,
        OP_ONE    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_LOAD_FIRST,
        CMD_LOAD,
        CMD_ONE,
        CMD_CLEAR,
        CMD_MUL,
        CMD_RESOLVE,
        CMD_COMMIT
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t  cmd;
        logic [7:0] fb;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_MUL,
        ST_RESOLVE,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

// File: hdl/bounded_bignum_multiply_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_bignum_multiply_top
// Multiplies a big-endian accumulator by a byte-wise loaded factor over a row
// of byte cells and streams the product as 64-bit words.
//
// channel  | direction | content
// s_axis   | in        | tdata data_byte, tuser op, tlast last
// m_axis   | out       | tdata word, tuser overflow, tlast last_res
// apb      | in/out    | register 0 width_bytes at address 0
//
// accumulator and factor bytes are taken only in the idle state
// a multiply clears the product, runs a multiply step for each factor byte and resolves carries,
// then emits the output words (one item on overflow) while m_tready is high
// the multiply rate is set by the row of cells, one factor byte per cycle
// no request is taken while a multiply runs or its words wait
// reset leaves the accumulator at one and the width at 256
// ----------------------------------------------------------------------------
module bounded_bignum_multiply_top
    import bbm_pkg::*;
#(
    parameter int MAX_WIDTH_BYTES  = MAX_WIDTH_BYTES_DEF,
    parameter int MAX_FACTOR_BYTES = MAX_FACTOR_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic [1:0]  s_tuser,   // op
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // word
    output logic             m_tuser,   // overflow
    output logic             m_tlast,   // last_res
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int MAXW = MAX_WIDTH_BYTES;
    localparam int MAXF = MAX_FACTOR_BYTES;
    localparam int WW   = $clog2(MAXW + 1);
    localparam int LW   = $clog2(MAXF + 1);
    localparam int FAW  = (MAXF > 1) ? $clog2(MAXF) : 1;
    localparam int NW   = (MAXW + 7) / 8;
    localparam int KW   = (NW > 1) ? $clog2(NW) : 1;

    state_t       state_reg, state_next;
    logic [8:0]   width_reg;
    logic         loading_reg, loading_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic         sticky_reg, sticky_next;
    logic         ovf_reg, ovf_next;
    logic [KW-1:0] k_reg, k_next;

    cell_ctrl_t   ctrl;
    logic         in_acc, out_acc, cfg_wr;
    op_t          op;
    logic [9:0]   wext, eff10;
    logic [WW-1:0] eff_w;
    logic [WW:0]  nw_full;
    logic [KW-1:0] k_top;
    logic         carry_any, oor_any, fall_mul, fall_res;
    logic         f_we;
    logic [FAW-1:0] f_raddr;
    logic [7:0]   f_rdata;

    logic [7:0]   acc_q [MAXW];
    logic [7:0]   p_q   [MAXW];
    logic [7:0]   c_q   [MAXW];
    logic [7:0]   pw    [MAXW+1];
    logic [7:0]   cw    [MAXW+2];
    logic [MAXW-1:0] in_range;
    logic [NW*64-1:0] pbits;

    assign op       = op_t'(s_tuser);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {23'd0, width_reg} : 32'd0;

    assign wext  = {1'b0, width_reg};
    assign eff10 = (wext == 10'd0) ? 10'd1 :
                   (wext > 10'(MAXW)) ? 10'(MAXW) : wext;
    assign eff_w   = WW'(eff10);
    assign nw_full = {1'b0, eff_w} + (WW+1)'(7);
    assign k_top   = KW'((nw_full >> 3) - (WW+1)'(1));

    // cell row
    assign pw[0] = 8'd0;
    assign cw[0] = 8'd0;
    assign cw[1] = 8'd0;

    genvar gi;
    generate
        for (gi = 0; gi < MAXW; gi++)
        begin : g_cell
            assign in_range[gi] = eff_w > WW'(gi);
            bbm_cell #(.IS_FIRST(gi == 0)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .in_range (in_range[gi]),
                .acc_prev ((gi == 0) ? s_tdata : acc_q[(gi > 0) ? gi - 1 : 0]),
                .p_prev   (pw[gi]),
                .c_prev   (cw[gi+1]),
                .c_prev2  (cw[gi]),
                .acc      (acc_q[gi]),
                .p        (p_q[gi]),
                .c        (c_q[gi])
            );
            assign pw[gi+1] = p_q[gi];
            assign cw[gi+2] = c_q[gi];
        end
        for (gi = 0; gi < NW*8; gi++)
        begin : g_pbits
            if (gi < MAXW)
            begin : g_in
                assign pbits[gi*8 +: 8] = p_q[gi];
            end
            else
            begin : g_pad
                assign pbits[gi*8 +: 8] = 8'd0;
            end
        end
    endgenerate

    always_comb
    begin
        carry_any = 1'b0;
        oor_any   = 1'b0;
        for (int i = 0; i < MAXW; i++)
        begin
            carry_any = carry_any | (c_q[i] != 8'd0);
            oor_any   = oor_any | (!in_range[i] && (p_q[i] != 8'd0));
        end
    end

    assign fall_mul = (pw[MAXW] != 8'd0) || (cw[MAXW] != 8'd0) || (cw[MAXW+1] != 8'd0);
    assign fall_res = cw[MAXW+1] != 8'd0;

    // factor store
    assign f_we    = in_acc && (op == OP_FACTOR) && (len_reg < LW'(MAXF));
    assign f_raddr = (state_reg == ST_PRE) ? FAW'(0) : FAW'(cnt_reg + LW'(1));

    bbm_fstore #(.DEPTH(MAXF), .AW(FAW)) u_fstore (
        .clk   (clk),
        .we    (f_we),
        .waddr (FAW'(len_reg)),
        .wdata (s_tdata),
        .raddr (f_raddr),
        .rdata (f_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (op == OP_FACTOR) && s_tlast)
                begin
                    state_next = ST_PRE;
                end
            end
            ST_PRE:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == len_reg - LW'(1))
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (!carry_any)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_acc && m_tlast)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        ctrl.cmd     = CMD_HOLD;
        ctrl.fb      = f_rdata;
        loading_next = loading_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        sticky_next  = sticky_reg;
        ovf_next     = ovf_reg;
        k_next       = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_acc)
                begin
                    case (op)
                        OP_LOAD:
                        begin
                            ctrl.cmd     = loading_reg ? CMD_LOAD : CMD_LOAD_FIRST;
                            loading_next = !s_tlast;
                        end
                        OP_ONE:
                        begin
                            ctrl.cmd     = CMD_ONE;
                            loading_next = 1'b0;
                        end
                        OP_FACTOR:
                        begin
                            if (len_reg < LW'(MAXF))
                            begin
                                len_next = len_reg + LW'(1);
                            end
                        end
                        default:
                        begin
                            ctrl.cmd = CMD_HOLD;
                        end
                    endcase
                end
            end
            ST_PRE:
            begin
                ctrl.cmd    = CMD_CLEAR;
                cnt_next    = '0;
                sticky_next = 1'b0;
            end
            ST_MUL:
            begin
                ctrl.cmd    = CMD_MUL;
                cnt_next    = cnt_reg + LW'(1);
                sticky_next = sticky_reg | fall_mul;
                if (cnt_reg == len_reg - LW'(1))
                begin
                    len_next = '0;
                end
            end
            ST_RESOLVE:
            begin
                if (carry_any)
                begin
                    ctrl.cmd    = CMD_RESOLVE;
                    sticky_next = sticky_reg | fall_res;
                end
                else
                begin
                    ovf_next = sticky_reg | oor_any;
                    k_next   = k_top;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                if (out_acc)
                begin
                    k_next = k_reg - KW'(1);
                    if (m_tlast && !ovf_reg)
                    begin
                        ctrl.cmd = CMD_COMMIT;
                    end
                end
            end
            default:
            begin
                ctrl.cmd = CMD_HOLD;
            end
        endcase
    end

    assign m_tuser = ovf_reg;
    assign m_tlast = ovf_reg || (k_reg == KW'(0));
    assign m_tdata = ovf_reg ? 64'd0 : pbits[k_reg*64 +: 64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            width_reg   <= WIDTH_RESET;
            loading_reg <= 1'b0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            sticky_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            loading_reg <= loading_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            sticky_reg  <= sticky_next;
            ovf_reg     <= ovf_next;
            k_reg       <= k_next;
            if (cfg_wr && (paddr[2] == 1'b0))
            begin
                width_reg <= pwdata[8:0];
            end
        end
    end

    a_ovf_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("overflow result not marked last");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("request taken while results pending");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (cnt_reg < len_reg))
        else $error("factor index past factor length");

    a_resolve_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESOLVE && !carry_any) |=> (state_reg == ST_EMIT))
        else $error("resolve did not hand over to emit");

    a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !carry_any)
        else $error("carries pending while emitting");

endmodule
`default_nettype wire

// File: hdl/bbm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbm_cell
// One byte of the accumulator and one byte of the carry-save product.
// ----------------------------------------------------------------------------
module bbm_cell
    import bbm_pkg::*;
#(
    parameter bit IS_FIRST = 1'b0
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       in_range,
    input  wire logic [7:0] acc_prev,
    input  wire logic [7:0] p_prev,
    input  wire logic [7:0] c_prev,
    input  wire logic [7:0] c_prev2,
    output logic [7:0]      acc,
    output logic [7:0]      p,
    output logic [7:0]      c
);

    logic [7:0]  acc_reg, acc_next;
    logic [7:0]  p_reg, p_next;
    logic [7:0]  c_reg, c_next;
    logic [15:0] mac;
    logic [8:0]  rsum;

    assign mac  = ({8'd0, acc_reg} * {8'd0, ctrl.fb}) + {8'd0, p_prev} + {8'd0, c_prev2};
    assign rsum = {1'b0, p_reg} + {1'b0, c_prev};

    always_comb
    begin
        case (ctrl.cmd)
            CMD_LOAD_FIRST: acc_next = IS_FIRST ? acc_prev : 8'd0;
            CMD_LOAD:       acc_next = acc_prev;
            CMD_ONE:        acc_next = IS_FIRST ? 8'd1 : 8'd0;
            CMD_COMMIT:     acc_next = p_reg;
            default:        acc_next = acc_reg;
        endcase
        if (!in_range)
        begin
            acc_next = 8'd0;
        end
    end

    always_comb
    begin
        case (ctrl.cmd)
            CMD_CLEAR:
            begin
                p_next = 8'd0;
                c_next = 8'd0;
            end
            CMD_MUL:
            begin
                p_next = mac[7:0];
                c_next = mac[15:8];
            end
            CMD_RESOLVE:
            begin
                p_next = rsum[7:0];
                c_next = {7'd0, rsum[8]};
            end
            default:
            begin
                p_next = p_reg;
                c_next = c_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= IS_FIRST ? 8'd1 : 8'd0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        c_reg <= c_next;
    end

    assign acc = acc_reg;
    assign p   = p_reg;
    assign c   = c_reg;

endmodule
`default_nettype wire

// File: hdl/bbm_fstore.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbm_fstore
// Factor byte store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bbm_fstore
    import bbm_pkg::*;
#(
    parameter int DEPTH = MAX_FACTOR_BYTES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [7:0]         rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded big-number multiplier: drives accumulator,
// factor, set-one and no-op requests on the input stream and APB width writes,
// and checks each word and its overflow and last flags against a byte-array model.
// ----------------------------------------------------------------------------
module tb_top;
    import bbm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [63:0] word;
        bit          ovf;
        bit          lst;
    } prod_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // data_byte
    logic [1:0]  s_tuser = '0;   // op
    logic        s_tlast = 1'b0; // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // word
    logic        m_tuser;        // overflow
    logic        m_tlast;        // last_res
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // product model state
    logic [7:0]  acc_bytes [MAX_WIDTH_BYTES_DEF];
    logic [7:0]  factor_bytes [MAX_FACTOR_BYTES_DEF];
    int          factor_len;
    bit          acc_loading;
    logic [8:0]  width_reg;

    prod_word_t  pending_words [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          tx_idle = 1'b1;
    bit          rx_idle = 1'b1;
    bit          hold_req = 1'b0;

    bounded_bignum_multiply_top uut (.*);

    always #6 clk = ~clk;

    function automatic int eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_WIDTH_BYTES_DEF)
            return MAX_WIDTH_BYTES_DEF;
        return int'(width_reg);
    endfunction

    function automatic void width_write(logic [8:0] v);
        int w;
        width_reg = v;
        w = eff_width();
        for (int i = w; i < MAX_WIDTH_BYTES_DEF; i++)
            acc_bytes[i] = '0;
    endfunction

    function automatic void set_acc_one();
        foreach (acc_bytes[i])
            acc_bytes[i] = '0;
        acc_bytes[0] = 8'd1;
    endfunction

    function automatic void predict_product(op_t op, logic [7:0] b, bit lst);
        int w;
        int n;
        int carry;
        int base;
        int prod [2 * MAX_WIDTH_BYTES_DEF + 8];
        bit ovf;
        prod_word_t pw;
        w = eff_width();
        case (op)
            OP_LOAD:
            begin
                if (!acc_loading)
                    foreach (acc_bytes[i])
                        acc_bytes[i] = '0;
                for (int i = w - 1; i > 0; i--)
                    acc_bytes[i] = acc_bytes[i - 1];
                acc_bytes[0] = b;
                acc_loading = !lst;
            end
            OP_ONE:
            begin
                set_acc_one();
                acc_loading = 1'b0;
            end
            OP_FACTOR:
            begin
                if (factor_len < MAX_FACTOR_BYTES_DEF)
                begin
                    factor_bytes[factor_len] = b;
                    factor_len++;
                end
                if (lst)
                begin
                    foreach (prod[i])
                        prod[i] = 0;
                    for (int a = 0; a < w; a++)
                        for (int k = 0; k < factor_len; k++)
                            prod[a + k] += acc_bytes[a] * factor_bytes[factor_len - 1 - k];
                    carry = 0;
                    ovf = 1'b0;
                    foreach (prod[i])
                    begin
                        carry += prod[i];
                        prod[i] = carry & 255;
                        carry = carry >> 8;
                        if (i >= w && prod[i] != 0)
                            ovf = 1'b1;
                    end
                    factor_len = 0;
                    if (ovf)
                    begin
                        pw.word = '0;
                        pw.ovf = 1'b1;
                        pw.lst = 1'b1;
                        pending_words.push_back(pw);
                    end
                    else
                    begin
                        for (int i = 0; i < w; i++)
                            acc_bytes[i] = prod[i][7:0];
                        n = (w + 7) / 8;
                        for (int k = 0; k < n; k++)
                        begin
                            base = (n - 1 - k) * 8;
                            pw.word = '0;
                            for (int i = 7; i >= 0; i--)
                                pw.word = {pw.word[55:0],
                                           (base + i < w) ? prod[base + i][7:0] : 8'd0};
                            pw.ovf = 1'b0;
                            pw.lst = (k == n - 1);
                            pending_words.push_back(pw);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        prod_word_t pw;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected word", m_tdata, '0);
            else
            begin
                pw = pending_words.pop_front();
                if (m_tdata !== pw.word)
                    report_mismatch("word", m_tdata, pw.word);
                if (m_tuser !== pw.ovf)
                    report_mismatch("overflow", 64'(m_tuser), 64'(pw.ovf));
                if (m_tlast !== pw.lst)
                    report_mismatch("last", 64'(m_tlast), 64'(pw.lst));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout");
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_request(op_t op, logic [7:0] b, bit lst);
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        s_tlast <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        predict_product(op, b, lst);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apb_write_width(logic [8:0] v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= '0;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        width_write(v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_acc(int len, bit zero_top);
        for (int i = 0; i < len; i++)
            send_request(OP_LOAD, (zero_top && i == 0) ? 8'd0 : 8'($urandom), i == len - 1);
    endtask

    task automatic send_factor(int len);
        for (int i = 0; i < len; i++)
            send_request(OP_FACTOR, 8'($urandom), i == len - 1);
    endtask

    task automatic test_directed();
        send_request(OP_ONE, 8'hff, 1'b0);
        send_request(OP_FACTOR, 8'hff, 1'b0);
        send_request(OP_FACTOR, 8'hff, 1'b1);
        send_request(OP_NONE, 8'h5a, 1'b1);
        apb_write_width(9'd9);
        send_request(OP_LOAD, 8'hff, 1'b0);
        send_request(OP_LOAD, 8'h00, 1'b0);
        send_request(OP_LOAD, 8'h80, 1'b1);
        send_request(OP_FACTOR, 8'h01, 1'b1);
        send_request(OP_FACTOR, 8'hff, 1'b1);
        send_request(OP_FACTOR, 8'h00, 1'b1);
        send_request(OP_LOAD, 8'h12, 1'b0);
        send_request(OP_ONE, 8'h00, 1'b1);
        send_request(OP_LOAD, 8'h34, 1'b1);
        for (int i = 0; i < 10; i++)
            send_request(OP_LOAD, 8'h11 * i[7:0], i == 9);
        send_request(OP_FACTOR, 8'hff, 1'b1);
        apb_write_width(9'd0);
        send_request(OP_FACTOR, 8'h01, 1'b1);
    endtask

    task automatic test_long_factor();
        apb_write_width(9'd256);
        send_request(OP_ONE, 8'h00, 1'b0);
        send_factor(262);
    endtask

    task automatic test_backpressure();
        apb_write_width(9'd8);
        hold_req = 1'b1;
        for (int s = 0; s < 4; s++)
        begin
            send_request(OP_ONE, 8'h00, 1'b0);
            send_factor($urandom_range(1, 3));
        end
        drain();
    endtask

    task automatic test_random(logic [8:0] v, int n_req);
        int w;
        int sent;
        int a_len;
        int f_len;
        apb_write_width(v);
        w = eff_width();
        sent = 0;
        while (sent < n_req)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    send_request(op_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
                    sent++;
                end
                2:
                begin
                    send_request(OP_ONE, 8'($urandom), 1'($urandom));
                    f_len = $urandom_range(1, (w > 4) ? 4 : w);
                    send_factor(f_len);
                    sent += 1 + f_len;
                end
                default:
                begin
                    a_len = $urandom_range(1, (w > 6) ? 6 : w + 2);
                    f_len = $urandom_range(1, (w > 4) ? 4 : 2);
                    send_acc(a_len, $urandom_range(0, 1));
                    send_factor(f_len);
                    sent += a_len + f_len;
                end
            endcase
        end
    endtask

    initial
    begin
        foreach (acc_bytes[i])
            acc_bytes[i] = '0;
        foreach (factor_bytes[i])
            factor_bytes[i] = '0;
        acc_bytes[0] = 8'd1;
        factor_len = 0;
        acc_loading = 1'b0;
        width_reg = WIDTH_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_factor();
        test_backpressure();
        test_random(9'd1, 20);
        test_random(9'd3, 20);
        test_random(9'd16, 25);
        test_random(9'd17, 25);
        test_random(9'd511, 20);
        test_random(9'd64, 20);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        test_random(9'd9, 25);
        drain();
        repeat (50) @(posedge clk);
        if (pending_words.size() != 0)
            report_mismatch("words never arrived", 64'(pending_words.size()), '0);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
